### rtl/core/tkea_pkg.sv
// ----------------------------------------------------------------------------
// tkea_pkg
// Shared widths, reset values, verdict codes and the queue entry type of the
// threshold Kruskal edge acceptor.
// ----------------------------------------------------------------------------
package tkea_pkg;

   // Default sizes handed to the top level parameters
   localparam int MAX_LEVELS_DEF = 1024;
   localparam int COST_BITS_DEF  = 40;

   // Fixed field widths
   localparam int DIFF_W      = 16;
   localparam int NODE_IN_W   = 10;
   localparam int CPD_W       = 10;
   localparam int FULL_W      = 16;
   localparam int NUM_W       = 11;
   localparam int ECOST_W     = DIFF_W + CPD_W;
   localparam int COMP_OUT_W  = 11;
   localparam int TOTAL_OUT_W = 40;

   // Register port
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_COST_PER_DIFF = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_FULL_COST     = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_LEVELS    = CSR_IDX_W'(2);

   localparam logic [CPD_W-1:0]  CPD_RESET  = CPD_W'(1);
   localparam logic [FULL_W-1:0] FULL_RESET = FULL_W'(100);
   localparam logic [NUM_W-1:0]  NUM_RESET  = NUM_W'(1024);

   // Queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   typedef enum logic [1:0] {
      VERDICT_ACCEPT = 2'd0,
      VERDICT_JOINED = 2'd1,
      VERDICT_REJECT = 2'd2
   } verdict_type;

   // One classified edge, as the front hands it to the back
   typedef struct packed {
      logic                 find_req;
      verdict_type          code;
      logic [NODE_IN_W-1:0] node_a;
      logic [NODE_IN_W-1:0] node_b;
      logic [ECOST_W-1:0]   edge_cost;
   } queue_entry_type;

endpackage

### rtl/core/tkea_ram.sv
// ----------------------------------------------------------------------------
// tkea_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module tkea_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write, then register the read word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/tkea_front.sv
// ----------------------------------------------------------------------------
// tkea_front
// Takes one edge request, prices it, applies the sticky cost stop and the node
// range test, and pushes the classified edge into the queue.
// ----------------------------------------------------------------------------
module tkea_front #(
   parameter int MAX_LEVELS = tkea_pkg::MAX_LEVELS_DEF,
   parameter int LVL_W      = $clog2(MAX_LEVELS + 1)
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            accept,
   input  logic [tkea_pkg::DIFF_W-1:0]     diff_count,
   input  logic [tkea_pkg::NODE_IN_W-1:0]  node_a,
   input  logic [tkea_pkg::NODE_IN_W-1:0]  node_b,
   input  logic [tkea_pkg::CPD_W-1:0]      cost_per_diff,
   input  logic [tkea_pkg::FULL_W-1:0]     full_cost,
   input  logic [LVL_W-1:0]                levels,
   output logic                            busy,
   input  logic                            q_full,
   output logic                            q_push,
   output tkea_pkg::queue_entry_type       q_data
);

   typedef enum logic [1:0] {
      F_IDLE,
      F_MUL,
      F_PUSH
   } front_state_type;

   front_state_type                 state_ff, state_in;
   logic [tkea_pkg::DIFF_W-1:0]     diff_ff, diff_in;
   logic [tkea_pkg::NODE_IN_W-1:0]  a_ff, a_in;
   logic [tkea_pkg::NODE_IN_W-1:0]  b_ff, b_in;
   logic [tkea_pkg::ECOST_W-1:0]    cost_ff, cost_in;
   logic                            stopped_ff, stopped_in;
   logic                            too_costly;
   logic                            out_of_range;

   assign too_costly   = cost_ff >= tkea_pkg::ECOST_W'(full_cost);
   assign out_of_range = (32'(a_ff) >= 32'(levels)) || (32'(b_ff) >= 32'(levels));

   // Sequence: capture request, multiply, classify and push
   always_comb begin
      state_in   = state_ff;
      diff_in    = diff_ff;
      a_in       = a_ff;
      b_in       = b_ff;
      cost_in    = cost_ff;
      stopped_in = stopped_ff;
      q_push     = 1'b0;

      q_data.find_req  = 1'b0;
      q_data.code      = tkea_pkg::VERDICT_REJECT;
      q_data.node_a    = a_ff;
      q_data.node_b    = b_ff;
      q_data.edge_cost = cost_ff;

      case (state_ff)
         F_IDLE: begin
            if (accept) begin
               diff_in  = diff_count;
               a_in     = node_a;
               b_in     = node_b;
               state_in = F_MUL;
            end
         end
         F_MUL: begin
            cost_in  = tkea_pkg::ECOST_W'(diff_ff) * tkea_pkg::ECOST_W'(cost_per_diff);
            state_in = F_PUSH;
         end
         F_PUSH: begin
            if (stopped_ff || too_costly) begin
               q_data.find_req = 1'b0;
            end else if (out_of_range) begin
               q_data.find_req = 1'b0;
            end else begin
               q_data.find_req = 1'b1;
            end
            if (!q_full) begin
               q_push   = 1'b1;
               state_in = F_IDLE;
               if (too_costly) begin
                  stopped_in = 1'b1;
               end
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   // Hold state, stop flag and the edge being classified
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= F_IDLE;
         stopped_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         stopped_ff <= stopped_in;
      end
      diff_ff <= diff_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      cost_ff <= cost_in;
   end

   assign busy = (state_ff != F_IDLE);

endmodule

### rtl/core/tkea_queue.sv
// ----------------------------------------------------------------------------
// tkea_queue
// Short first-in first-out queue of classified edges between front and back.
// ----------------------------------------------------------------------------
module tkea_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  tkea_pkg::queue_entry_type  push_data,
   output logic                       full,
   input  logic                       pop,
   output logic                       not_empty,
   output tkea_pkg::queue_entry_type  head
);

   localparam logic [tkea_pkg::QPTR_W-1:0] LAST_SLOT =
      tkea_pkg::QPTR_W'(tkea_pkg::QUEUE_DEPTH - 1);

   tkea_pkg::queue_entry_type        slot_ff [tkea_pkg::QUEUE_DEPTH];
   logic [tkea_pkg::QPTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [tkea_pkg::QPTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [tkea_pkg::QPTR_W:0]        count_ff, count_in;
   logic                             do_push;
   logic                             do_pop;

   assign full      = (count_ff == (tkea_pkg::QPTR_W + 1)'(tkea_pkg::QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign head      = slot_ff[rd_ptr_ff];

   // Advance pointers with wrap, track fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### rtl/core/tkea_back.sv
// ----------------------------------------------------------------------------
// tkea_back
// Clears the parent table after reset, then for each queued edge that passed
// the front's tests runs the two root lookups with path compression, merges
// differing sets, keeps the join count and the accepted cost sum, and issues
// one result per edge.
module tkea_back #(
   parameter int MAX_LEVELS = tkea_pkg::MAX_LEVELS_DEF,
   parameter int COST_BITS  = tkea_pkg::COST_BITS_DEF,
   parameter int LVL_W      = $clog2(MAX_LEVELS + 1)
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic [LVL_W-1:0]                     levels,
   input  logic [tkea_pkg::FULL_W-1:0]          full_cost,
   output logic                                 clear_done,
   input  logic                                 q_not_empty,
   input  tkea_pkg::queue_entry_type            q_head,
   output logic                                 q_pop,
   output logic                                 rsp_valid,
   output logic                                 rsp_accepted,
   output logic [1:0]                           rsp_verdict_code,
   output logic [tkea_pkg::COMP_OUT_W-1:0]      rsp_component_count,
   output logic [tkea_pkg::TOTAL_OUT_W-1:0]     rsp_total_cost
);

   localparam int NODE_W = $clog2(MAX_LEVELS);
   localparam int PROD_W = LVL_W + tkea_pkg::FULL_W;
   localparam int TSUM_W = ((COST_BITS > PROD_W) ? COST_BITS : PROD_W) + 1;
   localparam int ASUM_W = ((COST_BITS > tkea_pkg::ECOST_W) ?
                            COST_BITS : tkea_pkg::ECOST_W) + 1;
   localparam logic [TSUM_W-1:0]    TSUM_MAX  = TSUM_W'({COST_BITS{1'b1}});
   localparam logic [ASUM_W-1:0]    ASUM_MAX  = ASUM_W'({COST_BITS{1'b1}});
   localparam logic [NODE_W-1:0]    LAST_NODE = NODE_W'(MAX_LEVELS - 1);

   typedef enum logic [2:0] {
      B_CLEAR,
      B_IDLE,
      B_LAUNCH,
      B_WALK,
      B_COMP,
      B_MERGE,
      B_MUL,
      B_OUT
   } back_state_type;

   back_state_type                       state_ff, state_in;
   tkea_pkg::queue_entry_type            ent_ff, ent_in;
   logic                                 which_ff, which_in;
   logic [NODE_W-1:0]                    clr_ff, clr_in;
   logic [NODE_W-1:0]                    start_ff, start_in;
   logic [NODE_W-1:0]                    cur_ff, cur_in;
   logic [NODE_W-1:0]                    root_ff, root_in;
   logic [NODE_W-1:0]                    root_a_ff, root_a_in;
   logic [NODE_W-1:0]                    joins_ff, joins_in;
   logic [COST_BITS-1:0]                 sum_ff, sum_in;
   logic [PROD_W-1:0]                    prod_ff, prod_in;
   tkea_pkg::verdict_type                code_ff, code_in;
   logic                                 acc_ff, acc_in;
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic                                 rsp_acc_ff, rsp_acc_in;
   tkea_pkg::verdict_type                rsp_code_ff, rsp_code_in;
   logic [tkea_pkg::COMP_OUT_W-1:0]      rsp_comp_ff, rsp_comp_in;
   logic [tkea_pkg::TOTAL_OUT_W-1:0]     rsp_total_ff, rsp_total_in;

   logic                                 wr_en;
   logic [NODE_W-1:0]                    wr_addr;
   logic [NODE_W-1:0]                    wr_data;
   logic [NODE_W-1:0]                    rd_addr;
   logic [NODE_W-1:0]                    rd_data;
   logic                                 find_done;
   logic [NODE_W-1:0]                    find_root;
   logic [LVL_W-1:0]                     comps;
   logic [ASUM_W-1:0]                    asum;
   logic [TSUM_W-1:0]                    tsum;
   logic [COST_BITS-1:0]                 total_sat;

   tkea_ram #(
      .WIDTH (NODE_W),
      .DEPTH (MAX_LEVELS)
   ) u_parent_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Components left, never below one
   assign comps = (levels > LVL_W'(joins_ff)) ? (levels - LVL_W'(joins_ff)) : LVL_W'(1);

   // Saturating sums
   assign asum      = ASUM_W'(sum_ff) + ASUM_W'(ent_ff.edge_cost);
   assign tsum      = TSUM_W'(sum_ff) + TSUM_W'(prod_ff);
   assign total_sat = (tsum > TSUM_MAX) ? {COST_BITS{1'b1}} : COST_BITS'(tsum);

   // Sequencer for clearing, lookups, merge and result
   always_comb begin
      state_in     = state_ff;
      ent_in       = ent_ff;
      which_in     = which_ff;
      clr_in       = clr_ff;
      start_in     = start_ff;
      cur_in       = cur_ff;
      root_in      = root_ff;
      root_a_in    = root_a_ff;
      joins_in     = joins_ff;
      sum_in       = sum_ff;
      prod_in      = prod_ff;
      code_in      = code_ff;
      acc_in       = acc_ff;
      rsp_valid_in = 1'b0;
      rsp_acc_in   = rsp_acc_ff;
      rsp_code_in  = rsp_code_ff;
      rsp_comp_in  = rsp_comp_ff;
      rsp_total_in = rsp_total_ff;
      wr_en        = 1'b0;
      wr_addr      = cur_ff;
      wr_data      = root_ff;
      rd_addr      = cur_ff;
      q_pop        = 1'b0;
      find_done    = 1'b0;
      find_root    = root_ff;

      case (state_ff)
         B_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = clr_ff;
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == LAST_NODE) begin
               state_in = B_IDLE;
            end
         end
         B_IDLE: begin
            if (q_not_empty) begin
               q_pop    = 1'b1;
               ent_in   = q_head;
               which_in = 1'b0;
               start_in = NODE_W'(q_head.node_a);
               if (q_head.find_req) begin
                  state_in = B_LAUNCH;
               end else begin
                  code_in  = q_head.code;
                  acc_in   = 1'b0;
                  state_in = B_MUL;
               end
            end
         end
         B_LAUNCH: begin
            rd_addr  = start_ff;
            cur_in   = start_ff;
            state_in = B_WALK;
         end
         B_WALK: begin
            // rd_data is the parent of cur_ff
            if (rd_data == cur_ff) begin
               root_in = cur_ff;
               if (start_ff == cur_ff) begin
                  find_done = 1'b1;
                  find_root = cur_ff;
               end else begin
                  cur_in   = start_ff;
                  rd_addr  = start_ff;
                  state_in = B_COMP;
               end
            end else begin
               cur_in  = rd_data;
               rd_addr = rd_data;
            end
         end
         B_COMP: begin
            // point the node at the root, step to its old parent
            wr_en   = 1'b1;
            wr_addr = cur_ff;
            wr_data = root_ff;
            if (rd_data == root_ff) begin
               find_done = 1'b1;
               find_root = root_ff;
            end else begin
               cur_in  = rd_data;
               rd_addr = rd_data;
            end
         end
         B_MERGE: begin
            wr_en    = 1'b1;
            wr_addr  = root_a_ff;
            wr_data  = root_ff;
            joins_in = joins_ff + 1'b1;
            sum_in   = (asum > ASUM_MAX) ? {COST_BITS{1'b1}} : COST_BITS'(asum);
            code_in  = tkea_pkg::VERDICT_ACCEPT;
            acc_in   = 1'b1;
            state_in = B_MUL;
         end
         B_MUL: begin
            prod_in  = PROD_W'(comps) * PROD_W'(full_cost);
            state_in = B_OUT;
         end
         B_OUT: begin
            rsp_valid_in = 1'b1;
            rsp_acc_in   = acc_ff;
            rsp_code_in  = code_ff;
            rsp_comp_in  = tkea_pkg::COMP_OUT_W'(comps);
            rsp_total_in = tkea_pkg::TOTAL_OUT_W'(total_sat);
            state_in     = B_IDLE;
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase

      // A lookup has finished: start the second one or decide
      if (find_done) begin
         if (!which_ff) begin
            root_a_in = find_root;
            which_in  = 1'b1;
            start_in  = NODE_W'(ent_ff.node_b);
            state_in  = B_LAUNCH;
         end else begin
            root_in = find_root;
            if (root_a_ff == find_root) begin
               code_in  = tkea_pkg::VERDICT_JOINED;
               acc_in   = 1'b0;
               state_in = B_MUL;
            end else begin
               state_in = B_MERGE;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_CLEAR;
         clr_ff       <= '0;
         joins_ff     <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         joins_ff     <= joins_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ent_ff       <= ent_in;
      which_ff     <= which_in;
      start_ff     <= start_in;
      cur_ff       <= cur_in;
      root_ff      <= root_in;
      root_a_ff    <= root_a_in;
      prod_ff      <= prod_in;
      code_ff      <= code_in;
      acc_ff       <= acc_in;
      rsp_acc_ff   <= rsp_acc_in;
      rsp_code_ff  <= rsp_code_in;
      rsp_comp_ff  <= rsp_comp_in;
      rsp_total_ff <= rsp_total_in;
   end

   assign clear_done          = (state_ff != B_CLEAR);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_accepted        = rsp_acc_ff;
   assign rsp_verdict_code    = rsp_code_ff;
   assign rsp_component_count = rsp_comp_ff;
   assign rsp_total_cost      = rsp_total_ff;

endmodule

### rtl/core/threshold_kruskal_edge_acceptor.sv
// ----------------------------------------------------------------------------
// threshold_kruskal_edge_acceptor
// Edge acceptor for a minimum spanning tree built under a full-send cost cap.
// ----------------------------------------------------------------------------
// Start an edge with start while busy is low; each edge gives exactly one
// result, shown for one cycle with rsp_valid, in request order, and the
// receiver cannot hold it off. After reset the block is busy while the
// parent table is swept so every node is its own root. The front takes a
// new request once the previous one is pushed, while the two-entry queue
// has room. The back, which owns the parent table RAM ports, sets the rate;
// looked-up edges also walk both endpoints' pointer paths, which path
// compression keeps short. Registers on the csr_ port must be written only
// while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module threshold_kruskal_edge_acceptor #(
   parameter int MAX_LEVELS = tkea_pkg::MAX_LEVELS_DEF,
   parameter int COST_BITS  = tkea_pkg::COST_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // edge requests
   input  logic                                 start,
   output logic                                 busy,
   input  logic [tkea_pkg::DIFF_W-1:0]          req_diff_count,
   input  logic [tkea_pkg::NODE_IN_W-1:0]       req_node_a,
   input  logic [tkea_pkg::NODE_IN_W-1:0]       req_node_b,
   // results
   output logic                                 rsp_valid,
   output logic                                 rsp_accepted,
   output logic [1:0]                           rsp_verdict_code,
   output logic [tkea_pkg::COMP_OUT_W-1:0]      rsp_component_count,
   output logic [tkea_pkg::TOTAL_OUT_W-1:0]     rsp_total_cost,
   // register writes
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [tkea_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [tkea_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int LVL_W = $clog2(MAX_LEVELS + 1);

   logic [tkea_pkg::CPD_W-1:0]   cpd_ff, cpd_in;
   logic [tkea_pkg::FULL_W-1:0]  full_ff, full_in;
   logic [tkea_pkg::NUM_W-1:0]   num_ff, num_in;
   logic [LVL_W-1:0]             levels;
   logic                         front_busy;
   logic                         clear_done;
   logic                         accept;
   logic                         q_full;
   logic                         q_push;
   logic                         q_pop;
   logic                         q_not_empty;
   tkea_pkg::queue_entry_type    q_push_data;
   tkea_pkg::queue_entry_type    q_head;

   // Register writes
   assign csr_ready = 1'b1;

   always_comb begin
      cpd_in  = cpd_ff;
      full_in = full_ff;
      num_in  = num_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            tkea_pkg::CSR_COST_PER_DIFF: cpd_in  = tkea_pkg::CPD_W'(csr_wdata);
            tkea_pkg::CSR_FULL_COST:     full_in = csr_wdata;
            tkea_pkg::CSR_NUM_LEVELS:    num_in  = tkea_pkg::NUM_W'(csr_wdata);
            default: begin
               cpd_in = cpd_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cpd_ff  <= tkea_pkg::CPD_RESET;
         full_ff <= tkea_pkg::FULL_RESET;
         num_ff  <= tkea_pkg::NUM_RESET;
      end else begin
         cpd_ff  <= cpd_in;
         full_ff <= full_in;
         num_ff  <= num_in;
      end
   end

   // Clamp the node count into one to MAX_LEVELS
   always_comb begin
      if (num_ff == '0) begin
         levels = LVL_W'(1);
      end else if (32'(num_ff) > 32'(MAX_LEVELS)) begin
         levels = LVL_W'(MAX_LEVELS);
      end else begin
         levels = LVL_W'(num_ff);
      end
   end

   assign busy   = front_busy || !clear_done;
   assign accept = start && !busy;

   tkea_front #(
      .MAX_LEVELS (MAX_LEVELS),
      .LVL_W      (LVL_W)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .diff_count    (req_diff_count),
      .node_a        (req_node_a),
      .node_b        (req_node_b),
      .cost_per_diff (cpd_ff),
      .full_cost     (full_ff),
      .levels        (levels),
      .busy          (front_busy),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_data        (q_push_data)
   );

   tkea_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .head      (q_head)
   );

   tkea_back #(
      .MAX_LEVELS (MAX_LEVELS),
      .COST_BITS  (COST_BITS),
      .LVL_W      (LVL_W)
   ) u_back (
      .clock               (clock),
      .reset               (reset),
      .levels              (levels),
      .full_cost           (full_ff),
      .clear_done          (clear_done),
      .q_not_empty         (q_not_empty),
      .q_head              (q_head),
      .q_pop               (q_pop),
      .rsp_valid           (rsp_valid),
      .rsp_accepted        (rsp_accepted),
      .rsp_verdict_code    (rsp_verdict_code),
      .rsp_component_count (rsp_component_count),
      .rsp_total_cost      (rsp_total_cost)
   );

endmodule

### rtl/core/tkea_checker.sv
// ----------------------------------------------------------------------------
// tkea_checker
// Port-level checks on the edge acceptor, bound to the top level.
// ----------------------------------------------------------------------------
module tkea_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 start,
   input logic                                 busy,
   input logic                                 rsp_valid,
   input logic                                 rsp_accepted,
   input logic [1:0]                           rsp_verdict_code,
   input logic [tkea_pkg::COMP_OUT_W-1:0]      rsp_component_count
);

   // Reset starts the table sweep and drops any result
   assert property (@(posedge clock) reset |=> busy && !rsp_valid)
      else $error("block not busy or result shown after reset");

   // A taken request keeps the block busy in the next cycle
   assert property (@(posedge clock) disable iff (reset) start && !busy |=> busy)
      else $error("block not busy after taking a request");

   // Result strobes never come in back-to-back cycles
   assert property (@(posedge clock) disable iff (reset) rsp_valid |=> !rsp_valid)
      else $error("result strobes in consecutive cycles");

   // Accepted flag agrees with the verdict
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_accepted == (rsp_verdict_code == tkea_pkg::VERDICT_ACCEPT)))
      else $error("accepted flag disagrees with verdict");

   // Verdict is a known code and at least one component remains
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_verdict_code <= tkea_pkg::VERDICT_REJECT) &&
                    (rsp_component_count != '0))
      else $error("bad verdict code or zero components");

endmodule

bind threshold_kruskal_edge_acceptor tkea_checker u_tkea_checker (.*);

### tb/threshold_kruskal_edge_acceptor_tb.sv
// ----------------------------------------------------------------------------
// threshold_kruskal_edge_acceptor_tb
// Self-checking bench for the edge acceptor. A fixed list of edges and
// register writes runs first, with hand-worked verdicts for the plain cases.
// Random segments with fresh register settings follow, and then a tail that
// trips the cost cap. A union-find predictor tracks joins, the accepted cost
// and stop flag; each result is checked in order against it or a typed verdict.
// ----------------------------------------------------------------------------
module threshold_kruskal_edge_acceptor_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int          DIFF_W        = tkea_pkg::DIFF_W;
   localparam int          NODE_IN_W     = tkea_pkg::NODE_IN_W;
   localparam int          CPD_W         = tkea_pkg::CPD_W;
   localparam int          FULL_W        = tkea_pkg::FULL_W;
   localparam int          NUM_W         = tkea_pkg::NUM_W;
   localparam int          COMP_OUT_W    = tkea_pkg::COMP_OUT_W;
   localparam int          TOTAL_OUT_W   = tkea_pkg::TOTAL_OUT_W;
   localparam int          CSR_IDX_W     = tkea_pkg::CSR_IDX_W;
   localparam int          CSR_DATA_W    = tkea_pkg::CSR_DATA_W;

   localparam int          NODE_COUNT    = tkea_pkg::MAX_LEVELS_DEF;
   localparam logic [63:0] COST_CAP      = (64'd1 << tkea_pkg::COST_BITS_DEF) - 64'd1;
   localparam int          CYCLE_LIMIT   = 1_000_000;
   localparam int          DRAIN_CYCLES  = 64;
   localparam int          SEGMENTS      = 4;
   localparam int          SEG_EDGES     = 54;
   localparam int          DIRECTED_ROWS = 24;

   // Register indexes that decode to nothing, and a filler for edge rows
   localparam logic [CSR_IDX_W-1:0] BAD_REG_LOW  = CSR_IDX_W'(3);
   localparam logic [CSR_IDX_W-1:0] BAD_REG_HIGH = CSR_IDX_W'(255);
   localparam logic [CSR_IDX_W-1:0] UNUSED_REG   = CSR_IDX_W'(0);

   typedef struct packed {
      logic                   accepted;
      tkea_pkg::verdict_type  code;
      logic [COMP_OUT_W-1:0]  comps;
      logic [TOTAL_OUT_W-1:0] total;
   } edge_verdict_type;

   localparam edge_verdict_type NO_VERDICT = '0;

   typedef enum logic {
      ROW_EDGE,
      ROW_WRITE
   } row_kind_type;

   typedef struct packed {
      row_kind_type         kind;
      logic [15:0]          value;      // diff count or register data
      logic [NODE_IN_W-1:0] node_a;
      logic [NODE_IN_W-1:0] node_b;
      logic [CSR_IDX_W-1:0] index;
      logic                 typed;      // verdict below is hand-worked
      edge_verdict_type     verdict;
   } edge_row_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   start = 1'b0;
   logic                   busy;
   logic [DIFF_W-1:0]      req_diff_count = '0;
   logic [NODE_IN_W-1:0]   req_node_a = '0;
   logic [NODE_IN_W-1:0]   req_node_b = '0;
   logic                   rsp_valid;
   logic                   rsp_accepted;
   logic [1:0]             rsp_verdict_code;
   logic [COMP_OUT_W-1:0]  rsp_component_count;
   logic [TOTAL_OUT_W-1:0] rsp_total_cost;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_IDX_W-1:0]   csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   // Predictor state: registers, forest, running sums
   logic [CPD_W-1:0]  model_cpd       = tkea_pkg::CPD_RESET;
   logic [FULL_W-1:0] model_full      = tkea_pkg::FULL_RESET;
   logic [NUM_W-1:0]  model_levels    = tkea_pkg::NUM_RESET;
   int unsigned       link_up [NODE_COUNT];
   logic [63:0]       accepted_sum    = '0;
   int unsigned       joins_made      = 0;
   bit                model_stopped   = 1'b0;

   edge_verdict_type  pending_verdicts [$];
   int unsigned       sender_idle_pct = 0;
   int unsigned       error_count     = 0;
   int unsigned       results_seen    = 0;
   int unsigned       cycle_count     = 0;
   int unsigned       n_merged        = 0;
   int unsigned       n_joined        = 0;
   int unsigned       n_refused       = 0;
   int unsigned       n_writes        = 0;

   edge_row_type directed_rows [DIRECTED_ROWS] = '{
      '{ROW_EDGE,  16'd0,     10'd0,    10'd1,    UNUSED_REG,                  1'b1,
        '{1'b1, tkea_pkg::VERDICT_ACCEPT, 11'd1023, 40'd102300}},
      '{ROW_EDGE,  16'd5,     10'd1,    10'd0,    UNUSED_REG,                  1'b1,
        '{1'b0, tkea_pkg::VERDICT_JOINED, 11'd1023, 40'd102300}},
      '{ROW_EDGE,  16'd3,     10'd7,    10'd7,    UNUSED_REG,                  1'b1,
        '{1'b0, tkea_pkg::VERDICT_JOINED, 11'd1023, 40'd102300}},
      '{ROW_EDGE,  16'd99,    10'd2,    10'd1023, UNUSED_REG,                  1'b1,
        '{1'b1, tkea_pkg::VERDICT_ACCEPT, 11'd1022, 40'd102299}},
      '{ROW_WRITE, 16'd0,     10'd0,    10'd0,    tkea_pkg::CSR_COST_PER_DIFF, 1'b0,
        NO_VERDICT},
      '{ROW_EDGE,  16'hFFFF,  10'd1023, 10'd512,  UNUSED_REG,                  1'b1,
        '{1'b1, tkea_pkg::VERDICT_ACCEPT, 11'd1021, 40'd102199}},
      '{ROW_EDGE,  16'hFFFF,  10'd2,    10'd512,  UNUSED_REG,                  1'b1,
        '{1'b0, tkea_pkg::VERDICT_JOINED, 11'd1021, 40'd102199}},
      '{ROW_WRITE, 16'd512,   10'd0,    10'd0,    tkea_pkg::CSR_NUM_LEVELS,    1'b0,
        NO_VERDICT},
      '{ROW_EDGE,  16'd0,     10'd512,  10'd3,    UNUSED_REG,                  1'b1,
        '{1'b0, tkea_pkg::VERDICT_REJECT, 11'd509,  40'd50999}},
      '{ROW_EDGE,  16'd0,     10'd3,    10'd511,  UNUSED_REG,                  1'b1,
        '{1'b1, tkea_pkg::VERDICT_ACCEPT, 11'd508,  40'd50899}},
      '{ROW_WRITE, 16'd0,     10'd0,    10'd0,    tkea_pkg::CSR_NUM_LEVELS,    1'b0,
        NO_VERDICT},
      '{ROW_EDGE,  16'd0,     10'd0,    10'd0,    UNUSED_REG,                  1'b1,
        '{1'b0, tkea_pkg::VERDICT_JOINED, 11'd1,    40'd199}},
      '{ROW_EDGE,  16'd0,     10'd1,    10'd0,    UNUSED_REG,                  1'b1,
        '{1'b0, tkea_pkg::VERDICT_REJECT, 11'd1,    40'd199}},
      '{ROW_WRITE, 16'hFFFF,  10'd0,    10'd0,    tkea_pkg::CSR_NUM_LEVELS,    1'b0,
        NO_VERDICT},
      '{ROW_EDGE,  16'd0,     10'd100,  10'd200,  UNUSED_REG,                  1'b1,
        '{1'b1, tkea_pkg::VERDICT_ACCEPT, 11'd1019, 40'd101999}},
      '{ROW_WRITE, 16'hFFFF,  10'd0,    10'd0,    BAD_REG_LOW,                 1'b0,
        NO_VERDICT},
      '{ROW_WRITE, 16'h1234,  10'd0,    10'd0,    BAD_REG_HIGH,                1'b0,
        NO_VERDICT},
      '{ROW_EDGE,  16'd1,     10'd300,  10'd301,  UNUSED_REG,                  1'b1,
        '{1'b1, tkea_pkg::VERDICT_ACCEPT, 11'd1018, 40'd101899}},
      '{ROW_WRITE, 16'hFFFF,  10'd0,    10'd0,    tkea_pkg::CSR_FULL_COST,     1'b0,
        NO_VERDICT},
      '{ROW_WRITE, 16'd1000,  10'd0,    10'd0,    tkea_pkg::CSR_COST_PER_DIFF, 1'b0,
        NO_VERDICT},
      '{ROW_EDGE,  16'd65,    10'd10,   10'd11,   UNUSED_REG,                  1'b0,
        NO_VERDICT},
      '{ROW_EDGE,  16'd65,    10'd11,   10'd10,   UNUSED_REG,                  1'b0,
        NO_VERDICT},
      '{ROW_WRITE, 16'd1,     10'd0,    10'd0,    tkea_pkg::CSR_FULL_COST,     1'b0,
        NO_VERDICT},
      '{ROW_EDGE,  16'd0,     10'd10,   10'd12,   UNUSED_REG,                  1'b0,
        NO_VERDICT}
   };

   threshold_kruskal_edge_acceptor dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_diff_count      (req_diff_count),
      .req_node_a          (req_node_a),
      .req_node_b          (req_node_b),
      .rsp_valid           (rsp_valid),
      .rsp_accepted        (rsp_accepted),
      .rsp_verdict_code    (rsp_verdict_code),
      .rsp_component_count (rsp_component_count),
      .rsp_total_cost      (rsp_total_cost),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Hard stop on a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t ns: cycle limit reached with %0d results outstanding",
                  $time, pending_verdicts.size());
         $display("threshold_kruskal_edge_acceptor_tb: errors");
         $finish;
      end
   end

   function automatic logic [63:0] cap_cost(input logic [63:0] v);
      return (v > COST_CAP) ? COST_CAP : v;
   endfunction

   // Root lookup, pointing every node on the path at the root
   function automatic int unsigned find_root(input int unsigned node);
      int unsigned r;
      int unsigned cur;
      int unsigned nxt;
      r = node;
      while (link_up[r] != r) r = link_up[r];
      cur = node;
      while (cur != r) begin
         nxt = link_up[cur];
         link_up[cur] = r;
         cur = nxt;
      end
      return r;
   endfunction

   // Classify one edge and advance the forest, sums and stop flag
   function automatic edge_verdict_type judge_edge(input logic [DIFF_W-1:0] d,
                                                   input logic [NODE_IN_W-1:0] a,
                                                   input logic [NODE_IN_W-1:0] b);
      edge_verdict_type v;
      int unsigned      levels;
      int unsigned      ra;
      int unsigned      rb;
      int unsigned      comps;
      logic [63:0]      edge_cost;
      levels = model_levels;
      if (levels < 1) levels = 1;
      if (levels > NODE_COUNT) levels = NODE_COUNT;
      edge_cost = 64'(d) * 64'(model_cpd);
      v = NO_VERDICT;
      if (model_stopped || edge_cost >= 64'(model_full)) begin
         model_stopped = 1'b1;
         v.code = tkea_pkg::VERDICT_REJECT;
      end else if (a >= levels || b >= levels) begin
         v.code = tkea_pkg::VERDICT_REJECT;
      end else begin
         ra = find_root(a);
         rb = find_root(b);
         if (ra == rb) begin
            v.code = tkea_pkg::VERDICT_JOINED;
         end else begin
            link_up[ra] = rb;
            joins_made++;
            accepted_sum = cap_cost(accepted_sum + edge_cost);
            v.accepted = 1'b1;
            v.code = tkea_pkg::VERDICT_ACCEPT;
         end
      end
      case (v.code)
         tkea_pkg::VERDICT_ACCEPT: n_merged++;
         tkea_pkg::VERDICT_JOINED: n_joined++;
         default:                  n_refused++;
      endcase
      comps = (levels > joins_made) ? levels - joins_made : 1;
      v.comps = COMP_OUT_W'(comps);
      v.total = TOTAL_OUT_W'(cap_cost(accepted_sum + 64'(comps) * 64'(model_full)));
      return v;
   endfunction

   task automatic flag_mismatch(input string field, input logic [63:0] want,
                                input logic [63:0] got);
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      error_count++;
   endtask

   // Offer one edge and hold it until taken; then idle at random. On return
   // the caller drives the next edge or calls settle in the same step.
   task automatic send_edge(input logic [DIFF_W-1:0] d, input logic [NODE_IN_W-1:0] a,
                            input logic [NODE_IN_W-1:0] b, input bit typed,
                            input edge_verdict_type typed_verdict);
      edge_verdict_type predicted;
      req_diff_count <= d;
      req_node_a     <= a;
      req_node_b     <= b;
      start          <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      predicted = judge_edge(d, a, b);
      pending_verdicts.insert(pending_verdicts.size(), typed ? typed_verdict : predicted);
      while ($urandom_range(99) < sender_idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
   endtask

   // Drop start and hold until every result is back
   task automatic settle();
      start <= 1'b0;
      while (pending_verdicts.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_index <= idx;
      csr_wdata <= data;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         tkea_pkg::CSR_COST_PER_DIFF: model_cpd    = data[CPD_W-1:0];
         tkea_pkg::CSR_FULL_COST:     model_full   = data[FULL_W-1:0];
         tkea_pkg::CSR_NUM_LEVELS:    model_levels = data[NUM_W-1:0];
         default: ;
      endcase
      n_writes++;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Check each result against the oldest prediction
   always @(posedge clock) begin
      edge_verdict_type want;
      if (!reset && rsp_valid) begin
         results_seen++;
         if (pending_verdicts.size() == 0) begin
            $display("%0t ns: result with no request outstanding, verdict %0d",
                     $time, rsp_verdict_code);
            error_count++;
         end else begin
            want = pending_verdicts.pop_front();
            if (rsp_accepted !== want.accepted)
               flag_mismatch("accepted", 64'(want.accepted), 64'(rsp_accepted));
            if (rsp_verdict_code !== want.code)
               flag_mismatch("verdict_code", 64'(want.code), 64'(rsp_verdict_code));
            if (rsp_component_count !== want.comps)
               flag_mismatch("component_count", 64'(want.comps), 64'(rsp_component_count));
            if (rsp_total_cost !== want.total)
               flag_mismatch("total_cost", 64'(want.total), 64'(rsp_total_cost));
         end
      end
   end

   initial begin
      int unsigned          idle_by_phase [3];
      int unsigned          cfg_cpd;
      int unsigned          cfg_full;
      int unsigned          cfg_num;
      int unsigned          eff;
      int unsigned          wsize;
      int unsigned          base;
      int unsigned          roll;
      int unsigned          max_d;
      logic [DIFF_W-1:0]    d;
      logic [NODE_IN_W-1:0] a;
      logic [NODE_IN_W-1:0] b;
      logic [NODE_IN_W-1:0] swap;

      idle_by_phase = '{32, 52, 0};
      for (int i = 0; i < NODE_COUNT; i++) link_up[i] = i;

      // Hold reset, then release it
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed list
      sender_idle_pct = idle_by_phase[0];
      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_WRITE) begin
            settle();
            write_reg(directed_rows[i].index, directed_rows[i].value);
         end else begin
            send_edge(directed_rows[i].value, directed_rows[i].node_a,
                      directed_rows[i].node_b, directed_rows[i].typed,
                      directed_rows[i].verdict);
         end
      end

      // Random segments, each with its own register setting
      for (int phase = 0; phase < 3; phase++) begin
         sender_idle_pct = idle_by_phase[phase];
         for (int seg = 0; seg < SEGMENTS; seg++) begin
            case (seg)
               0:       cfg_cpd = 0;
               1:       cfg_cpd = $urandom_range(1, 20);
               2:       cfg_cpd = $urandom_range(0, 1000);
               default: cfg_cpd = 1000;
            endcase
            if (seg == 1) cfg_full = $urandom_range(100, 65535);
            else if (seg == 3 && phase == 2) cfg_full = 65535;
            else cfg_full = $urandom_range(1, 65535);
            roll = $urandom_range(9);
            if (roll == 0) cfg_num = 0;
            else if (roll == 1) cfg_num = $urandom_range(NODE_COUNT + 1, 2047);
            else if (roll < 4) cfg_num = $urandom_range(1, 16);
            else if (roll < 6) cfg_num = NODE_COUNT;
            else cfg_num = $urandom_range(1, NODE_COUNT);
            settle();
            write_reg(tkea_pkg::CSR_COST_PER_DIFF, {6'($urandom), 10'(cfg_cpd)});
            write_reg(tkea_pkg::CSR_FULL_COST, 16'(cfg_full));
            write_reg(tkea_pkg::CSR_NUM_LEVELS, {5'($urandom), 11'(cfg_num)});

            eff = cfg_num;
            if (eff < 1) eff = 1;
            if (eff > NODE_COUNT) eff = NODE_COUNT;
            wsize = $urandom_range(2, 40);
            if (wsize > eff) wsize = eff;
            base = $urandom_range(0, eff - wsize);
            max_d = (cfg_cpd == 0) ? 0 : (cfg_full - 1) / cfg_cpd;

            for (int k = 0; k < SEG_EDGES; k++) begin
               // keep every edge under the cap so the block does not stop early
               d = (cfg_cpd == 0) ? DIFF_W'($urandom) : DIFF_W'($urandom_range(0, max_d));
               roll = $urandom_range(99);
               a = NODE_IN_W'(base + $urandom_range(0, wsize - 1));
               b = NODE_IN_W'(base + $urandom_range(0, wsize - 1));
               if (roll < 8) begin
                  // endpoint beyond the node count, or any node when all are in use
                  if (eff < NODE_COUNT) a = NODE_IN_W'($urandom_range(eff, NODE_COUNT - 1));
                  else a = NODE_IN_W'($urandom);
                  if ($urandom_range(1)) begin
                     swap = a;
                     a = b;
                     b = swap;
                  end
               end else if (roll < 14) begin
                  b = a;
               end else if (roll < 24) begin
                  a = NODE_IN_W'($urandom_range(0, eff - 1));
                  b = NODE_IN_W'($urandom_range(0, eff - 1));
               end
               send_edge(d, a, b, 1'b0, NO_VERDICT);
               if ($urandom_range(99) == 0) settle();
            end
         end
      end

      // Drain once in mid-stream, then trip the cap exactly and check it sticks
      settle();
      write_reg(tkea_pkg::CSR_NUM_LEVELS, 16'(NODE_COUNT));
      write_reg(tkea_pkg::CSR_COST_PER_DIFF, 16'd10);
      write_reg(tkea_pkg::CSR_FULL_COST, 16'd50);
      send_edge(16'd4, NODE_IN_W'($urandom), NODE_IN_W'($urandom), 1'b0, NO_VERDICT);
      send_edge(16'd5, NODE_IN_W'($urandom), NODE_IN_W'($urandom), 1'b0, NO_VERDICT);
      send_edge(16'd0, NODE_IN_W'($urandom), NODE_IN_W'($urandom), 1'b0, NO_VERDICT);
      settle();
      write_reg(tkea_pkg::CSR_FULL_COST, 16'd0);
      for (int k = 0; k < 4; k++)
         send_edge(DIFF_W'($urandom), NODE_IN_W'($urandom), NODE_IN_W'($urandom),
                   1'b0, NO_VERDICT);

      // Wait out the last results and watch for strays
      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d edges: %0d merged, %0d already joined, %0d refused; %0d writes",
               n_merged + n_joined + n_refused, n_merged, n_joined, n_refused, n_writes);
      $display("results checked %0d, mismatches %0d", results_seen, error_count);
      if (error_count == 0)
         $display("threshold_kruskal_edge_acceptor_tb: clean");
      else
         $display("threshold_kruskal_edge_acceptor_tb: errors");
      $finish;
   end

endmodule
